### rtl/core/tcw_pkg.sv
package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int IDX_W   = $clog2(CELLS);
  localparam int CUR_W   = $clog2(CELLS + 1);

  // Row of the cursor by reciprocal multiplication: the scale is large enough
  // that the rounded-up reciprocal stays exact for every cell index.
  localparam int ROW_W      = $clog2(ROWS);
  localparam int ROW_SHIFT  = $clog2(CELLS * COLUMNS);
  localparam int ROW_RECIP  = (2 ** ROW_SHIFT + COLUMNS - 1) / COLUMNS;
  localparam int ROW_PROD_W = CUR_W + ROW_SHIFT;

  // Field widths.
  localparam int POS_W  = 11;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd32;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  // Request function codes.
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_SET   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_SET,
    CUR_ZERO,
    CUR_SCROLL,
    CUR_NL,
    CUR_INC
  } cur_op_e;

  typedef struct packed {
    logic    latch;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    fill_wr;
    logic    fill_rst;
    logic    scroll_rd;
    logic    scroll_wr;
    logic    char_wr;
    logic    cell_rd;
    logic    row_load;
    logic    result_load;
    cur_op_e cursor_op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       cursor_full;
    logic       is_newline;
    logic       cnt_scroll_last;
    logic       cnt_last;
    logic       out_busy;
  } dp_stat_t;

endpackage

### rtl/core/tcw_ctrl.sv
module tcw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tcw_pkg::dp_stat_t stat_i,
  output tcw_pkg::dp_cmd_t  cmd_o
);
  import tcw_pkg::*;

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_SCR_RD   = 4'd3;
  localparam logic [3:0] S_SCR_WR   = 4'd4;
  localparam logic [3:0] S_SCR_FILL = 4'd5;
  localparam logic [3:0] S_PUT      = 4'd6;
  localparam logic [3:0] S_NEWLINE  = 4'd7;
  localparam logic [3:0] S_CLR      = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        // Power-up sweep writes blanks with the reset attribute.
        cmd_o.fill_wr  = 1'b1;
        cmd_o.fill_rst = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (stat_i.cnt_last) begin
          cmd_o.cnt_inc = 1'b0;
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.func)
          FUNC_PUT: begin
            if (stat_i.cursor_full) begin
              cmd_o.cnt_clr = 1'b1;
              state_d       = S_SCR_RD;
            end else begin
              state_d = S_PUT;
            end
          end
          FUNC_SET: begin
            cmd_o.cursor_op = CUR_SET;
            state_d         = S_DONE;
          end
          FUNC_CLEAR: begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_CLR;
          end
          default: begin
            cmd_o.cell_rd = 1'b1;
            state_d       = S_DONE;
          end
        endcase
      end
      S_SCR_RD: begin
        cmd_o.scroll_rd = 1'b1;
        state_d         = S_SCR_WR;
      end
      S_SCR_WR: begin
        cmd_o.scroll_wr = 1'b1;
        cmd_o.cnt_inc   = 1'b1;
        state_d         = stat_i.cnt_scroll_last ? S_SCR_FILL : S_SCR_RD;
      end
      S_SCR_FILL: begin
        cmd_o.fill_wr = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.cnt_last) begin
          cmd_o.cnt_inc   = 1'b0;
          cmd_o.cnt_clr   = 1'b1;
          cmd_o.cursor_op = CUR_SCROLL;
          state_d         = S_PUT;
        end
      end
      S_PUT: begin
        if (stat_i.is_newline) begin
          cmd_o.row_load = 1'b1;
          state_d        = S_NEWLINE;
        end else begin
          cmd_o.char_wr   = 1'b1;
          cmd_o.cursor_op = CUR_INC;
          state_d         = S_DONE;
        end
      end
      S_NEWLINE: begin
        // The registered row of the cursor gives the start of the next row.
        cmd_o.cursor_op = CUR_NL;
        state_d         = S_DONE;
      end
      S_CLR: begin
        cmd_o.fill_wr = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.cnt_last) begin
          cmd_o.cnt_inc   = 1'b0;
          cmd_o.cnt_clr   = 1'b1;
          cmd_o.cursor_op = CUR_ZERO;
          state_d         = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.result_load = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/tcw_dp.sv
module tcw_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tcw_pkg::dp_cmd_t           cmd_i,
  output tcw_pkg::dp_stat_t          stat_o,
  input  logic [1:0]                 func_i,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  logic [tcw_pkg::POS_W-1:0]  position_i,
  input  logic                       cfg_valid_i,
  input  logic [tcw_pkg::ATTR_W-1:0] text_attr_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tcw_pkg::POS_W-1:0]  cursor_pos_o,
  output logic [tcw_pkg::CHAR_W-1:0] cell_char_o,
  output logic [tcw_pkg::ATTR_W-1:0] cell_attr_o
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] screen_q [CELLS];
  logic [CELL_W-1:0] rd_data_q;

  logic [CUR_W-1:0]  cursor_q, cursor_d;
  logic [IDX_W-1:0]  cnt_q;
  logic [ATTR_W-1:0] attr_q;
  logic              out_valid_q;

  logic [1:0]          func_q;
  logic [CHAR_W-1:0]   char_q;
  logic [CUR_W-1:0]    pos_q;
  logic [ROW_W-1:0]    row_q;
  logic [ROW_PROD_W-1:0] row_prod;
  logic [CUR_W-1:0]    pos_clamp;
  logic                pos_hit;

  logic [CUR_W-1:0]  res_cursor_q;
  logic [CHAR_W-1:0] res_char_q;
  logic [ATTR_W-1:0] res_attr_q;

  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ATTR_W-1:0] fill_attr;

  assign pos_clamp = (32'(position_i) > CELLS) ? CUR_W'(CELLS) : CUR_W'(position_i);
  assign pos_hit   = (32'(pos_q) < CELLS);
  assign row_prod  = ROW_PROD_W'(cursor_q) * ROW_PROD_W'(ROW_RECIP);

  assign stat_o.func            = func_q;
  assign stat_o.cursor_full     = (32'(cursor_q) >= CELLS);
  assign stat_o.is_newline      = (char_q == NEWLINE_CODE);
  assign stat_o.cnt_scroll_last = (cnt_q == IDX_W'(CELLS - COLUMNS - 1));
  assign stat_o.cnt_last        = (cnt_q == IDX_W'(CELLS - 1));
  assign stat_o.out_busy        = out_valid_q && out_stall_i;

  always_comb begin
    case (cmd_i.cursor_op)
      CUR_SET:    cursor_d = pos_q;
      CUR_ZERO:   cursor_d = '0;
      CUR_SCROLL: cursor_d = CUR_W'(CELLS - COLUMNS);
      CUR_NL:     cursor_d = CUR_W'((32'(row_q) + 1) * COLUMNS);
      CUR_INC:    cursor_d = cursor_q + CUR_W'(1);
      default:    cursor_d = cursor_q;
    endcase
  end

  // One write port and one registered read port on the screen store.
  assign fill_attr = cmd_i.fill_rst ? RESET_ATTR : attr_q;
  assign mem_we    = cmd_i.fill_wr || cmd_i.scroll_wr || cmd_i.char_wr;
  assign mem_waddr = cmd_i.char_wr ? cursor_q[IDX_W-1:0] : cnt_q;
  assign mem_re    = cmd_i.scroll_rd || (cmd_i.cell_rd && pos_hit);
  assign mem_raddr = cmd_i.scroll_rd ? IDX_W'(32'(cnt_q) + COLUMNS) : pos_q[IDX_W-1:0];

  always_comb begin
    if (cmd_i.fill_wr) begin
      mem_wdata = {fill_attr, {CHAR_W{1'b0}}};
    end else if (cmd_i.scroll_wr) begin
      mem_wdata = rd_data_q;
    end else begin
      mem_wdata = {attr_q, char_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= screen_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      cnt_q       <= '0;
      attr_q      <= RESET_ATTR;
      out_valid_q <= 1'b0;
    end else begin
      cursor_q <= cursor_d;
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end
      if (cfg_valid_i) begin
        attr_q <= text_attr_i;
      end
      if (cmd_i.result_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_i;
      char_q <= char_code_i;
      pos_q  <= pos_clamp;
    end
    if (cmd_i.row_load) begin
      row_q <= row_prod[ROW_SHIFT +: ROW_W];
    end
    if (cmd_i.result_load) begin
      res_cursor_q <= cursor_q;
      if (func_q == FUNC_READ && pos_hit) begin
        res_char_q <= rd_data_q[CHAR_W-1:0];
        res_attr_q <= rd_data_q[CELL_W-1:CHAR_W];
      end else begin
        res_char_q <= '0;
        res_attr_q <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_pos_o = POS_W'(res_cursor_q);
  assign cell_char_o  = res_char_q;
  assign cell_attr_o  = res_attr_q;

endmodule

### rtl/core/text_console_writer.sv
// Text console writer: an 80x25 screen of character/attribute cells with a cursor.
// After reset the block sweeps the whole screen to blanks, one cell a cycle, and
// holds in_stall_o high for the whole sweep. Requests are then taken one at a
// time; for a newline the row of the cursor is found by a multiplication with
// the reciprocal of the row length. A put with the cursor at the end of the
// screen first scrolls, moving each cell up a row through the store (read, then
// write) and blanking the last row; a clear blanks the screen one cell a cycle.
// Every request yields one result in an output register, so the next request may
// be accepted while the result is still stalled; that request then waits in its
// last state until the register is free. The attribute register may be written
// at any time the block is idle and takes effect for later writes, scrolls and
// clears.
module text_console_writer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 func_i,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  logic [tcw_pkg::POS_W-1:0]  position_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tcw_pkg::POS_W-1:0]  cursor_pos_o,
  output logic [tcw_pkg::CHAR_W-1:0] cell_char_o,
  output logic [tcw_pkg::ATTR_W-1:0] cell_attr_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0] text_attr_i
);
  import tcw_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tcw_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .func_i       (func_i),
    .char_code_i  (char_code_i),
    .position_i   (position_i),
    .cfg_valid_i  (cfg_valid_i),
    .text_attr_i  (text_attr_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cursor_pos_o (cursor_pos_o),
    .cell_char_o  (cell_char_o),
    .cell_attr_o  (cell_attr_o)
  );

endmodule

### rtl/core/tcw_checker.sv
module tcw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [10:0] cursor_pos_o,
  input logic [7:0]  cell_char_o,
  input logic [7:0]  cell_attr_o
);
  import tcw_pkg::*;

  // A held result must not change under stall.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cursor_pos_o)
      && $stable(cell_char_o) && $stable(cell_attr_o))
    else $error("result changed while stalled");

  // The cursor never goes past one beyond the last cell.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cursor_pos_o <= CELLS))
    else $error("cursor beyond screen end");

  // Only one request is in flight: the block stalls right after taking one.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

  // A result only shows up at the end of a request, while the input is stalled.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .cursor_pos_o (cursor_pos_o),
  .cell_char_o  (cell_char_o),
  .cell_attr_o  (cell_attr_o)
);
